FILE: sv/sthc_pkg.sv
package sthc_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int MAX_W    = 31;
    localparam int CH_W     = 8;
    localparam int NLO_W    = 3;
    localparam int SEG_W    = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MAX_W;

    // Defaults
    localparam int               COLOR_BITS_DEF = 8;
    localparam logic [MAX_W-1:0] MAX_RESET      = MAX_W'(65536);
    localparam logic [CH_W-1:0]  CH_FULL        = {CH_W{1'b1}};
    localparam logic [CH_W-1:0]  CH_ZERO        = '0;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_VALUE = 1'b0,
        REG_ABS_INPUT = 1'b1
    } t_reg_idx;

    // Range flag codes
    typedef enum logic [1:0] {
        RANGE_OK    = 2'd0,
        RANGE_BLACK = 2'd1,
        RANGE_CLAMP = 2'd2
    } t_range;

endpackage

FILE: sv/sthc_front.sv
module sthc_front import sthc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // upstream side
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [MAX_W-1:0]    i_max_value,
    input  logic                i_abs_input,
    // toward the first divider cell
    output logic                o_valid,
    input  logic                i_ready,
    output t_range              o_flag,
    output logic [MAX_W-1:0]    o_m,
    output logic [MAX_W-1:0]    o_rem,
    output logic [NLO_W-1:0]    o_nlo
);

    // stage A: magnitude
    logic                r_a_valid;
    logic                r_a_neg;
    logic [SAMPLE_W-1:0] r_a_mag;
    logic [MAX_W-1:0]    r_a_m;
    logic                a_ready;
    logic                n_a_neg;
    logic [SAMPLE_W-1:0] n_a_mag;

    // stage B: range check and scaled distance to max
    logic                r_b_valid;
    t_range              r_b_flag;
    logic [MAX_W-1:0]    r_b_m;
    logic [MAX_W-1:0]    r_b_rem;
    logic [NLO_W-1:0]    r_b_nlo;
    logic                b_ready;
    t_range              n_b_flag;
    logic [SAMPLE_W-1:0] b_diff;
    logic [MAX_W+1:0]    b_n;

    assign o_ready = a_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign b_ready = !r_b_valid || i_ready;

    // absolute value when abs_input is set; the most negative sample gives 2^31 exactly
    always_comb begin
        n_a_neg = i_sample[SAMPLE_W-1] && !i_abs_input;
        if (i_abs_input && i_sample[SAMPLE_W-1]) begin
            n_a_mag = ~i_sample + SAMPLE_W'(1);
        end else begin
            n_a_mag = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && a_ready) begin
            r_a_neg <= n_a_neg;
            r_a_mag <= n_a_mag;
            r_a_m   <= i_max_value;
        end
    end

    // n = 4*(m - s); divider starts from n/8 and feeds the low three bits
    always_comb begin
        b_diff = {1'b0, r_a_m} - r_a_mag;
        b_n    = {b_diff[MAX_W-1:0], 2'b00};
        if (r_a_m == '0 || r_a_neg) begin
            n_b_flag = RANGE_BLACK;
        end else if (r_a_mag > {1'b0, r_a_m}) begin
            n_b_flag = RANGE_CLAMP;
        end else begin
            n_b_flag = RANGE_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && b_ready) begin
            r_b_flag <= n_b_flag;
            r_b_m    <= r_a_m;
            r_b_rem  <= {1'b0, b_n[MAX_W+1:NLO_W]};
            r_b_nlo  <= b_n[NLO_W-1:0];
        end
    end

    assign o_valid = r_b_valid;
    assign o_flag  = r_b_flag;
    assign o_m     = r_b_m;
    assign o_rem   = r_b_rem;
    assign o_nlo   = r_b_nlo;

endmodule

FILE: sv/sthc_cell.sv
module sthc_cell import sthc_pkg::*; #(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_range                 i_flag,
    input  logic [MAX_W-1:0]       i_m,
    input  logic [MAX_W-1:0]       i_rem,
    input  logic [NLO_W-1:0]       i_nlo,
    input  logic [COLOR_BITS+2:0]  i_quo,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_range                 o_flag,
    output logic [MAX_W-1:0]       o_m,
    output logic [MAX_W-1:0]       o_rem,
    output logic [NLO_W-1:0]       o_nlo,
    output logic [COLOR_BITS+2:0]  o_quo
);

    localparam int QW = COLOR_BITS + SEG_W;

    logic             r_valid;
    t_range           r_flag;
    logic [MAX_W-1:0] r_m;
    logic [MAX_W-1:0] r_rem;
    logic [NLO_W-1:0] r_nlo;
    logic [QW-1:0]    r_quo;
    logic [MAX_W:0]   part;
    logic [MAX_W:0]   diff;
    logic             q_bit;
    logic [MAX_W-1:0] n_rem;

    assign o_ready = !r_valid || i_ready;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        part  = {i_rem, i_nlo[NLO_W-1]};
        diff  = part - {1'b0, i_m};
        q_bit = part >= {1'b0, i_m};
        n_rem = q_bit ? diff[MAX_W-1:0] : part[MAX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_flag <= i_flag;
            r_m    <= i_m;
            r_rem  <= n_rem;
            r_nlo  <= {i_nlo[NLO_W-2:0], 1'b0};
            r_quo  <= {i_quo[QW-2:0], q_bit};
        end
    end

    assign o_valid = r_valid;
    assign o_flag  = r_flag;
    assign o_m     = r_m;
    assign o_rem   = r_rem;
    assign o_nlo   = r_nlo;
    assign o_quo   = r_quo;

    // partial remainder stays below the divisor for in-range items
    a_rem_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_flag == RANGE_OK) |-> (r_rem < r_m))
        else $error("divider cell remainder not below max");

endmodule

FILE: sv/sthc_back.sv
module sthc_back import sthc_pkg::*; #(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_range                i_flag,
    input  logic [COLOR_BITS+2:0] i_quo,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CH_W-1:0]       o_red,
    output logic [CH_W-1:0]       o_green,
    output logic [CH_W-1:0]       o_blue,
    output t_range                o_flag
);

    localparam int RW = COLOR_BITS + CH_W + 1;
    localparam logic [RW-1:0] ROUND = RW'(1) << (COLOR_BITS - 1);
    localparam logic [COLOR_BITS:0] ONE_K = (COLOR_BITS + 1)'(1) << COLOR_BITS;

    // hue segments, red end first
    localparam logic [SEG_W-1:0] SEG_GREEN_UP  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_RED_DOWN  = 3'd1;
    localparam logic [SEG_W-1:0] SEG_BLUE_UP   = 3'd2;
    localparam logic [SEG_W-1:0] SEG_GREEN_DN  = 3'd3;

    logic                  r_valid;
    logic [CH_W-1:0]       r_red;
    logic [CH_W-1:0]       r_green;
    logic [CH_W-1:0]       r_blue;
    t_range                r_flag;
    logic [SEG_W-1:0]      seg;
    logic [COLOR_BITS-1:0] fq;
    logic [COLOR_BITS:0]   kq;
    logic [RW-1:0]         t_sum;
    logic [RW-1:0]         q_sum;
    logic [CH_W-1:0]       t_ch;
    logic [CH_W-1:0]       q_ch;
    logic [CH_W-1:0]       n_red;
    logic [CH_W-1:0]       n_green;
    logic [CH_W-1:0]       n_blue;

    assign o_ready = !r_valid || i_ready;

    // ramps: (k*255 + half) >> COLOR_BITS, k*255 as k*256 - k
    always_comb begin
        seg   = i_quo[COLOR_BITS+SEG_W-1:COLOR_BITS];
        fq    = i_quo[COLOR_BITS-1:0];
        kq    = ONE_K - {1'b0, fq};
        t_sum = ({{(CH_W+1){1'b0}}, fq} << CH_W) - {{(CH_W+1){1'b0}}, fq} + ROUND;
        q_sum = ({{CH_W{1'b0}}, kq} << CH_W) - {{CH_W{1'b0}}, kq} + ROUND;
        t_ch  = t_sum[COLOR_BITS +: CH_W];
        q_ch  = q_sum[COLOR_BITS +: CH_W];
    end

    // channel select per segment and range case
    always_comb begin
        n_red   = CH_ZERO;
        n_green = CH_ZERO;
        n_blue  = CH_ZERO;
        case (i_flag)
            RANGE_BLACK: begin
            end
            RANGE_CLAMP: begin
                n_red = CH_FULL;
            end
            default: begin
                case (seg)
                    SEG_GREEN_UP: begin
                        n_red   = CH_FULL;
                        n_green = t_ch;
                    end
                    SEG_RED_DOWN: begin
                        n_red   = q_ch;
                        n_green = CH_FULL;
                    end
                    SEG_BLUE_UP: begin
                        n_green = CH_FULL;
                        n_blue  = t_ch;
                    end
                    SEG_GREEN_DN: begin
                        n_green = q_ch;
                        n_blue  = CH_FULL;
                    end
                    default: begin
                        n_red  = t_ch;
                        n_blue = CH_FULL;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_flag  <= i_flag;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_flag  = r_flag;

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_flag == RANGE_BLACK) |->
        (r_red == CH_ZERO && r_green == CH_ZERO && r_blue == CH_ZERO))
        else $error("black item has a lit channel");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_flag == RANGE_CLAMP) |->
        (r_red == CH_FULL && r_green == CH_ZERO && r_blue == CH_ZERO))
        else $error("clamped item is not pure red");

    a_full_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_flag == RANGE_OK) |->
        (r_red == CH_FULL || r_green == CH_FULL || r_blue == CH_FULL))
        else $error("in-range item has no full channel");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_flag == RANGE_OK) |-> (seg <= SEG_W'(4)))
        else $error("hue segment out of range");

endmodule

FILE: sv/scalar_to_heat_color_top.sv
// Channel   Direction  Width            Contents
// s_axis    in         tdata 32         sample_value (signed Q16.16)
// m_axis    out        tdata 24, tuser 2  red, green, blue / range_flag
// cfg       in         idx 1, data 31   0: max_value, 1: abs_input
//
// One item per clock sustained while the output does not stall.
// The quotient 4*(max - sample)/max is formed by a row of
// COLOR_BITS + 3 restoring-divider cells, one quotient bit per cell.
// Every stage holds its own valid bit and fills bubbles when the output stalls.
// Reset is synchronous, active low: clears all valid bits, sets max_value to 1.0 and abs_input to 0.
module scalar_to_heat_color_top import sthc_pkg::*; #(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*CH_W-1:0]     m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic [1:0]            m_axis_tuser,   // [1:0] range_flag
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = COLOR_BITS + SEG_W;

    logic [MAX_W-1:0] r_max_value;
    logic             r_abs_input;

    logic             w_valid [QW+1];
    logic             w_ready [QW+1];
    t_range           w_flag  [QW+1];
    logic [MAX_W-1:0] w_m     [QW+1];
    logic [MAX_W-1:0] w_rem   [QW+1];
    logic [NLO_W-1:0] w_nlo   [QW+1];
    logic [QW-1:0]    w_quo   [QW+1];

    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    t_range           out_flag;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= MAX_RESET;
            r_abs_input <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MAX_VALUE: r_max_value <= i_cfg_data;
                REG_ABS_INPUT: r_abs_input <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    sthc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .i_max_value (r_max_value),
        .i_abs_input (r_abs_input),
        .o_valid     (w_valid[0]),
        .i_ready     (w_ready[0]),
        .o_flag      (w_flag[0]),
        .o_m         (w_m[0]),
        .o_rem       (w_rem[0]),
        .o_nlo       (w_nlo[0])
    );

    assign w_quo[0] = '0;

    // divider row
    for (genvar gi = 0; gi < QW; gi++) begin : g_cell
        sthc_cell #(.COLOR_BITS(COLOR_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[gi]),
            .o_ready (w_ready[gi]),
            .i_flag  (w_flag[gi]),
            .i_m     (w_m[gi]),
            .i_rem   (w_rem[gi]),
            .i_nlo   (w_nlo[gi]),
            .i_quo   (w_quo[gi]),
            .o_valid (w_valid[gi+1]),
            .i_ready (w_ready[gi+1]),
            .o_flag  (w_flag[gi+1]),
            .o_m     (w_m[gi+1]),
            .o_rem   (w_rem[gi+1]),
            .o_nlo   (w_nlo[gi+1]),
            .o_quo   (w_quo[gi+1])
        );
    end

    sthc_back #(.COLOR_BITS(COLOR_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[QW]),
        .o_ready (w_ready[QW]),
        .i_flag  (w_flag[QW]),
        .i_quo   (w_quo[QW]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue),
        .o_flag  (out_flag)
    );

    assign m_axis_tdata = {blue, green, red};
    assign m_axis_tuser = out_flag;

endmodule

FILE: tb/sv/heat_color_checker.sv
module heat_color_checker import sthc_pkg::*; #(
    parameter int COLOR_BITS = COLOR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sample_valid,
    input  logic                  i_sample_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,       // [31:0] sample_value
    input  logic                  i_color_valid,
    input  logic                  i_color_ready,
    input  logic [3*CH_W-1:0]     i_color,        // [7:0] red, [15:8] green, [23:16] blue
    input  logic [1:0]            i_range,        // [1:0] range_flag
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_in_range,
    output int                    o_black,
    output int                    o_clamped
);

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
        t_range              flag;
    } t_heat_color;

    // Local copy of the two registers, tracked from the write port
    logic [MAX_W-1:0] full_scale    = MAX_RESET;
    logic             use_magnitude = 1'b0;

    // Colors owed by the block, oldest first
    t_heat_color expected_colors[$];

    // Channel level for a ramp position k out of 2^COLOR_BITS, rounded
    function automatic logic [CH_W-1:0] ramp_level(longint k);
        longint lvl;
        lvl = (k * longint'(CH_FULL) + (longint'(1) << (COLOR_BITS - 1))) >>> COLOR_BITS;
        return CH_W'(lvl);
    endfunction

    // Heat color of one sample: hue runs from blue (0) to red (full scale)
    function automatic t_heat_color heat_color_of(logic [SAMPLE_W-1:0] sample,
                                                  logic [MAX_W-1:0] scale,
                                                  logic magnitude);
        t_heat_color c;
        longint      mag;
        longint      m;
        longint      span;
        longint      seg;
        longint      frac;
        logic [CH_W-1:0] rise;
        logic [CH_W-1:0] fall;
        c.sample = sample;
        c.red    = CH_ZERO;
        c.green  = CH_ZERO;
        c.blue   = CH_ZERO;
        c.flag   = RANGE_OK;
        mag = longint'($signed(sample));
        if (magnitude && mag < 0)
            mag = -mag;
        m = longint'(scale);
        if (m == 0 || mag < 0) begin
            c.flag = RANGE_BLACK;
        end else if (mag > m) begin
            c.red  = CH_FULL;
            c.flag = RANGE_CLAMP;
        end else begin
            // 4*(m - s) / m gives the hue segment, the remainder its fraction
            span = 4 * (m - mag);
            seg  = span / m;
            frac = ((span % m) << COLOR_BITS) / m;
            rise = ramp_level(frac);
            fall = ramp_level((longint'(1) << COLOR_BITS) - frac);
            case (seg)
                0: begin c.red = CH_FULL; c.green = rise; end
                1: begin c.red = fall;    c.green = CH_FULL; end
                2: begin c.green = CH_FULL; c.blue = rise; end
                3: begin c.green = fall;  c.blue = CH_FULL; end
                default: begin c.red = rise; c.blue = CH_FULL; end
            endcase
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : watch_edge
        t_heat_color     want;
        logic [CH_W-1:0] got_r;
        logic [CH_W-1:0] got_g;
        logic [CH_W-1:0] got_b;
        if (!i_rst_n) begin
            full_scale    = MAX_RESET;
            use_magnitude = 1'b0;
            expected_colors.delete();
            o_fail_count  = 0;
            o_in_range    = 0;
            o_black       = 0;
            o_clamped     = 0;
        end else begin
            // Sample accepted: predict with the registers as they stand now
            if (i_sample_valid && i_sample_ready)
                expected_colors.push_back(
                    heat_color_of(i_sample, full_scale, use_magnitude));

            // Color accepted: compare with the oldest prediction
            if (i_color_valid && i_color_ready) begin
                got_r = i_color[CH_W-1:0];
                got_g = i_color[2*CH_W-1:CH_W];
                got_b = i_color[3*CH_W-1:2*CH_W];
                if (expected_colors.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: color %0d,%0d,%0d flag %0d arrived, none owed",
                                 got_r, got_g, got_b, i_range);
                    o_fail_count++;
                end else begin
                    want = expected_colors.pop_front();
                    if (got_r !== want.red || got_g !== want.green || got_b !== want.blue
                            || i_range !== want.flag) begin
                        if (o_fail_count < 10)
                            $display({"ERROR: sample %h: expected rgb %0d,%0d,%0d flag %0d,",
                                      " got %0d,%0d,%0d flag %0d"},
                                     want.sample, want.red, want.green, want.blue,
                                     want.flag, got_r, got_g, got_b, i_range);
                        o_fail_count++;
                    end
                    case (want.flag)
                        RANGE_BLACK: o_black++;
                        RANGE_CLAMP: o_clamped++;
                        default:     o_in_range++;
                    endcase
                end
            end

            // Register writes take effect for later samples
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_MAX_VALUE: full_scale = i_cfg_data;
                    REG_ABS_INPUT: use_magnitude = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_colors.size();
    end

endmodule

FILE: tb/sv/tb.sv
module tb;
    import sthc_pkg::*;

    localparam int HALF_A         = 6;
    localparam int HALF_B         = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_PHASES     = 8;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_data  = '0;
    logic                  m_axis_tvalid;
    logic                  m_ready = 1'b0;
    logic [3*CH_W-1:0]     m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_we  = 1'b0;
    t_reg_idx              cfg_idx = REG_MAX_VALUE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int colors_owed;
    int in_range_count;
    int black_count;
    int clamp_count;

    // Stall control for the stimulus and the output side, plus progress counters
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit hold_request    = 1'b0;
    int samples_sent    = 0;
    int idle_cycles     = 0;

    always begin
        #HALF_A i_clk = 1'b1;
        #HALF_B i_clk = 1'b0;
    end

    scalar_to_heat_color_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    heat_color_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (s_valid),
        .i_sample_ready (s_axis_tready),
        .i_sample       (s_data),
        .i_color_valid  (m_axis_tvalid),
        .i_color_ready  (m_ready),
        .i_color        (m_axis_tdata),
        .i_range        (m_axis_tuser),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (colors_owed),
        .o_in_range     (in_range_count),
        .o_black        (black_count),
        .o_clamped      (clamp_count)
    );

    // Offer one sample after a random gap and wait for it to be taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Stop offering, let every owed color come out, then write both registers
    task automatic set_registers(input logic [MAX_W-1:0] scale, input logic magnitude);
        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (colors_owed == 0);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MAX_VALUE;
        cfg_data <= scale;
        @(posedge i_clk);
        // upper bits of the flag word are junk on purpose
        cfg_idx  <= REG_ABS_INPUT;
        cfg_data <= {(CFG_DATA_W-1)'($urandom), magnitude};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Samples weighted toward the colored range of the current scale
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [MAX_W-1:0] scale);
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] wide;
        int                  kind;
        kind = $urandom_range(0, 9);
        wide = SAMPLE_W'(scale);
        case (kind)
            0, 1, 2, 3, 4, 5: v = SAMPLE_W'($urandom_range(0, scale));
            6: v = wide + SAMPLE_W'($urandom_range(1, 3));
            7: v = SAMPLE_W'(0) - SAMPLE_W'($urandom_range(0, scale));
            8: v = $urandom;
            default: begin
                case ($urandom_range(0, 6))
                    0: v = '0;
                    1: v = wide;
                    2: v = wide + 1;
                    3: v = wide - 1;
                    4: v = 32'h8000_0000;
                    5: v = 32'h7FFF_FFFF;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // Output side: random stall per item, plus one long hold on request
    initial begin : color_sink
        int stall;
        int held;
        wait (i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge i_clk);
            end
            if ($urandom_range(0, 39) == 0)
                receiver_steady = !receiver_steady;
            stall = receiver_steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_ready));
        end
    end

    // Watchdog: any handshake or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d colors still owed",
                     idle_cycles, colors_owed);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [SAMPLE_W-1:0] directed[$];
        logic [MAX_W-1:0]    scale;
        logic                magnitude;
        int                  phase;
        int                  count;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset value (scale 1.0, signed): segment edges,
        // equal to max, just above, most negative, largest positive
        directed = '{32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000,
                     32'h0001_0000, 32'h0001_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'h8000_0000, 32'h0000_0001};
        foreach (directed[i]) send_sample(directed[i]);

        // Widest scale with magnitude: most negative sample clamps
        set_registers(31'h7FFF_FFFF, 1'b1);
        directed = '{32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                     32'h0000_0000};
        foreach (directed[i]) send_sample(directed[i]);

        // Zero scale gives black for everything
        set_registers('0, 1'b0);
        directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
        foreach (directed[i]) send_sample(directed[i]);

        // Scale of one LSB
        set_registers(31'd1, 1'b1);
        directed = '{32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 32'hFFFF_FFFF};
        foreach (directed[i]) send_sample(directed[i]);

        // Random phases, each with its own register setting
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            magnitude = 1'($urandom);
            case (phase)
                0: scale = MAX_RESET;
                1: begin scale = 31'h7FFF_FFFF; magnitude = 1'b1; end
                2: begin scale = 31'd1; magnitude = 1'b0; end
                3: begin scale = MAX_W'($urandom_range(2, 1 << 20)); magnitude = 1'b1; end
                4: scale = '0;
                5: scale = MAX_W'($urandom);
                6: scale = MAX_W'($urandom_range(1, 8));
                default: scale = MAX_W'($urandom_range(1000, 32'h00FF_FFFF));
            endcase
            set_registers(scale, magnitude);
            count = (phase == 4) ? 40 : 110;
            if (phase == 3)
                hold_request = 1'b1;
            repeat (count) send_sample(pick_sample(scale));
        end

        // Drain, then watch a little longer for stray colors
        s_valid <= 1'b0;
        @(posedge i_clk);
        wait (colors_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples over %0d register settings, one long output hold.",
                 samples_sent, NUM_PHASES + 4);
        $display("Colors checked: %0d in range, %0d black, %0d clamped to red.",
                 in_range_count, black_count, clamp_count);
        if (fail_count == 0 && colors_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d colors never arrived", fail_count, colors_owed);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
